// ===== hw/rtl/swam_pkg.sv =====
// Package for the sliding-window anagram matcher: command codes and internal op type.
`timescale 1ns / 1ps

package swam_pkg;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;  // unused code, does nothing

    // What a request does once decoded at the front end
    typedef enum logic [2:0] {
        OP_NOP,     // ignored request: no state change
        OP_CLEAR,   // return every store to reset
        OP_PATTERN, // one more pattern letter
        OP_CHECK,   // text letter with an empty pattern: report only
        OP_GROW,    // text letter, window still filling
        OP_SLIDE    // text letter, oldest letter leaves the window
    } op_t;

endpackage

// ===== hw/rtl/sliding_window_anagram_match.sv =====
// Sliding-window anagram matcher: letter histograms held in dual-read memories.
`timescale 1ns / 1ps

// Streaming anagram search over a small alphabet.
// Request channel (cmd_valid / cmd_stall, fields cmd and letter): clear, add a
// pattern letter, or present a text letter. Result channel (res_valid /
// res_stall, fields window_match and found): one result for every request.
// Pipeline: the request edge updates pointer, length and fill registers and
// reads the history ring; the edge moving it into stage 3 reads the count
// memories at the new and the leaving letter; the edge on which stage 3 fires
// writes the counts back, updates the mismatch counter and loads the result
// register. One request is taken every cycle while cmd_stall is low; forwarding
// the last write to each count memory covers a read-modify-write that overlaps.
// Counts are kept as two wrap-around tallies per letter (additions and
// removals); a letter differs from the pattern when the two tallies differ.
// Reset (and a clear request, as it retires) empties all state; per-letter
// valid bits make every count read as zero at once, so no clearing pass.
// When the receiver stalls, the result register holds and the pipeline
// keeps filling its empty stages; requests stall only once it is full.
module sliding_window_anagram_match
    import swam_pkg::*;
#(
    parameter int MAX_LEN  = 64,
    parameter int ALPHABET = 26
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] cmd,
    input  logic [4:0] letter,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       window_match,
    output logic       found
);

    localparam int AW = $clog2(ALPHABET);                       // letter address
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;    // ring pointer
    localparam int LW = $clog2(MAX_LEN + 1);                    // pattern length
    localparam int CW = $clog2(MAX_LEN + 1) + 1;                // wrapping tally
    localparam int MW = $clog2(ALPHABET + 1);                   // mismatch count

    // ---------------- front end (request edge) ----------------
    logic           acc;
    logic           letter_ok;
    logic [AW-1:0]  letter_idx;
    op_t            op_new;
    logic [PW-1:0]  ring_ptr_reg,  ring_ptr_next;
    logic [LW-1:0]  pat_len_reg,   pat_len_next;
    logic [LW-1:0]  win_fill_reg,  win_fill_next;
    logic [LW:0]    rp_ext, pl_ext, drop_wide;
    logic [PW-1:0]  drop_idx;
    logic           ring_we;

    logic [AW-1:0]  ring_mem [MAX_LEN];
    logic [AW-1:0]  ring_rd_reg;

    // stage 2
    logic           s2_valid_reg, s2_valid_next;
    op_t            s2_op_reg;
    logic [AW-1:0]  s2_letter_reg;

    // stage 3
    logic           s3_valid_reg, s3_valid_next;
    op_t            s3_op_reg;
    logic [AW-1:0]  s3_letter_reg;
    logic [AW-1:0]  s3_drop_reg;

    logic           adv2, adv3, s3_fire;

    // count memories: additions and removals per letter
    logic [CW-1:0]  inc_mem [ALPHABET];
    logic [CW-1:0]  dec_mem [ALPHABET];
    logic [CW-1:0]  inc_l_reg, inc_d_reg, dec_l_reg, dec_d_reg;
    logic [ALPHABET-1:0] inc_vld_reg, inc_vld_next;
    logic [ALPHABET-1:0] dec_vld_reg, dec_vld_next;

    // last write to each memory, for same-edge forwarding
    logic           inc_lw_en_reg, inc_lw_en_next;
    logic [AW-1:0]  inc_lw_addr_reg;
    logic [CW-1:0]  inc_lw_val_reg;
    logic           dec_lw_en_reg, dec_lw_en_next;
    logic [AW-1:0]  dec_lw_addr_reg;
    logic [CW-1:0]  dec_lw_val_reg;

    logic           inc_we, dec_we;
    logic [AW-1:0]  dec_waddr;
    logic [CW-1:0]  inc_wval, dec_wval;

    logic [CW-1:0]  il, id, dl, dd;
    logic [CW-1:0]  diff_l, diff_d;
    logic           bl, al, bd, ad, track_d;
    logic [1:0]     up_cnt, dn_cnt;

    logic [MW-1:0]  mismatch_reg, mismatch_next;
    logic           found_flag_reg, found_flag_next;
    logic           match_new;

    logic           res_valid_reg, res_valid_next;
    logic           window_match_reg;
    logic           found_reg;

    assign acc        = cmd_valid && !cmd_stall;
    assign letter_ok  = 32'(letter) < ALPHABET;
    assign letter_idx = AW'(letter);

    // slot of the letter that leaves: ring_ptr - pat_len, modulo MAX_LEN
    always_comb
    begin
        rp_ext    = (LW+1)'(ring_ptr_reg);
        pl_ext    = (LW+1)'(pat_len_reg);
        drop_wide = (rp_ext >= pl_ext) ? rp_ext - pl_ext
                                       : rp_ext + (LW+1)'(MAX_LEN) - pl_ext;
        drop_idx  = PW'(drop_wide);
    end

    always_comb
    begin
        op_new        = OP_NOP;
        ring_ptr_next = ring_ptr_reg;
        pat_len_next  = pat_len_reg;
        win_fill_next = win_fill_reg;
        case (cmd)
            CMD_CLEAR:
            begin
                op_new        = OP_CLEAR;
                ring_ptr_next = '0;
                pat_len_next  = '0;
                win_fill_next = '0;
            end
            CMD_PATTERN:
            begin
                if (letter_ok && (pat_len_reg < LW'(MAX_LEN)))
                begin
                    op_new       = OP_PATTERN;
                    pat_len_next = pat_len_reg + 1'b1;
                end
            end
            CMD_TEXT:
            begin
                if (letter_ok)
                begin
                    if (pat_len_reg == '0)
                        op_new = OP_CHECK;
                    else
                    begin
                        if (win_fill_reg >= pat_len_reg)
                            op_new = OP_SLIDE;
                        else
                        begin
                            op_new        = OP_GROW;
                            win_fill_next = win_fill_reg + 1'b1;
                        end
                        ring_ptr_next = (ring_ptr_reg == PW'(MAX_LEN - 1)) ? '0
                                                                   : ring_ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                op_new = OP_NOP;
            end
        endcase
    end

    assign ring_we = acc && ((op_new == OP_GROW) || (op_new == OP_SLIDE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_ptr_reg <= '0;
            pat_len_reg  <= '0;
            win_fill_reg <= '0;
        end
        else if (acc)
        begin
            ring_ptr_reg <= ring_ptr_next;
            pat_len_reg  <= pat_len_next;
            win_fill_reg <= win_fill_next;
        end
    end

    // history ring: read returns the old entry when the same slot is written
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_ptr_reg] <= letter_idx;
        if (acc)
            ring_rd_reg <= ring_mem[drop_idx];
    end

    // ---------------- pipeline flow ----------------
    assign adv3      = !res_valid_reg || !res_stall;
    assign s3_fire   = s3_valid_reg && adv3;
    assign adv2      = !s3_valid_reg || adv3;
    assign cmd_stall = s2_valid_reg && !adv2;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (acc)
            s2_valid_next = 1'b1;
        else if (adv2)
            s2_valid_next = 1'b0;

        s3_valid_next = s3_valid_reg;
        if (adv2)
            s3_valid_next = s2_valid_reg;

        res_valid_next = res_valid_reg;
        if (adv3)
            res_valid_next = s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s2_op_reg     <= op_new;
            s2_letter_reg <= letter_idx;
        end
        if (adv2)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_letter_reg <= s2_letter_reg;
            s3_drop_reg   <= ring_rd_reg;
        end
    end

    // ---------------- count memories ----------------
    always_comb
    begin
        inc_we    = s3_fire && ((s3_op_reg == OP_GROW) || (s3_op_reg == OP_SLIDE));
        inc_wval  = il + 1'b1;
        dec_we    = s3_fire && ((s3_op_reg == OP_PATTERN) || (s3_op_reg == OP_SLIDE));
        dec_waddr = (s3_op_reg == OP_SLIDE) ? s3_drop_reg : s3_letter_reg;
        dec_wval  = (s3_op_reg == OP_SLIDE) ? dd + 1'b1 : dl + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (inc_we)
            inc_mem[s3_letter_reg] <= inc_wval;
        if (adv2)
        begin
            inc_l_reg <= inc_mem[s2_letter_reg];
            inc_d_reg <= inc_mem[ring_rd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_we)
            dec_mem[dec_waddr] <= dec_wval;
        if (adv2)
        begin
            dec_l_reg <= dec_mem[s2_letter_reg];
            dec_d_reg <= dec_mem[ring_rd_reg];
        end
    end

    // never-written (since clear) reads zero; a write at the read edge forwards
    always_comb
    begin
        if (!inc_vld_reg[s3_letter_reg])
            il = '0;
        else if (inc_lw_en_reg && (inc_lw_addr_reg == s3_letter_reg))
            il = inc_lw_val_reg;
        else
            il = inc_l_reg;

        if (!inc_vld_reg[s3_drop_reg])
            id = '0;
        else if (inc_lw_en_reg && (inc_lw_addr_reg == s3_drop_reg))
            id = inc_lw_val_reg;
        else
            id = inc_d_reg;

        if (!dec_vld_reg[s3_letter_reg])
            dl = '0;
        else if (dec_lw_en_reg && (dec_lw_addr_reg == s3_letter_reg))
            dl = dec_lw_val_reg;
        else
            dl = dec_l_reg;

        if (!dec_vld_reg[s3_drop_reg])
            dd = '0;
        else if (dec_lw_en_reg && (dec_lw_addr_reg == s3_drop_reg))
            dd = dec_lw_val_reg;
        else
            dd = dec_d_reg;
    end

    // ---------------- mismatch tracking ----------------
    always_comb
    begin
        diff_l  = il - dl;
        diff_d  = id - dd;
        bl      = diff_l != '0;
        al      = bl;
        bd      = diff_d != '0;
        ad      = bd;
        track_d = 1'b0;
        case (s3_op_reg)
            OP_PATTERN:
            begin
                al = (diff_l - 1'b1) != '0;
            end
            OP_GROW:
            begin
                al = (diff_l + 1'b1) != '0;
            end
            OP_SLIDE:
            begin
                // same letter in and out: its difference is unchanged
                if (s3_drop_reg != s3_letter_reg)
                begin
                    al      = (diff_l + 1'b1) != '0;
                    ad      = (diff_d - 1'b1) != '0;
                    track_d = 1'b1;
                end
            end
            default:
            begin
                al = bl;
            end
        endcase

        up_cnt = 2'(!bl && al) + 2'(track_d && !bd && ad);
        dn_cnt = 2'(bl && !al) + 2'(track_d && bd && !ad);
        // only count updates move the tally; other requests may carry any letter
        if (!(s3_op_reg inside {OP_PATTERN, OP_GROW, OP_SLIDE}))
        begin
            up_cnt = '0;
            dn_cnt = '0;
        end

        mismatch_next = mismatch_reg + MW'(up_cnt) - MW'(dn_cnt);
        if (s3_op_reg == OP_CLEAR)
            mismatch_next = '0;

        match_new = ((s3_op_reg == OP_CHECK) || (s3_op_reg == OP_GROW)
                     || (s3_op_reg == OP_SLIDE)) && (mismatch_next == '0);

        found_flag_next = found_flag_reg || match_new;
        if (s3_op_reg == OP_CLEAR)
            found_flag_next = 1'b0;
    end

    always_comb
    begin
        inc_vld_next   = inc_vld_reg;
        dec_vld_next   = dec_vld_reg;
        inc_lw_en_next = inc_lw_en_reg;
        dec_lw_en_next = dec_lw_en_reg;
        if (s3_fire)
        begin
            if (s3_op_reg == OP_CLEAR)
            begin
                inc_vld_next   = '0;
                dec_vld_next   = '0;
                inc_lw_en_next = 1'b0;
                dec_lw_en_next = 1'b0;
            end
            else
            begin
                if (inc_we)
                begin
                    inc_vld_next[s3_letter_reg] = 1'b1;
                    inc_lw_en_next              = 1'b1;
                end
                if (dec_we)
                begin
                    dec_vld_next[dec_waddr] = 1'b1;
                    dec_lw_en_next          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_vld_reg    <= '0;
            dec_vld_reg    <= '0;
            inc_lw_en_reg  <= 1'b0;
            dec_lw_en_reg  <= 1'b0;
            mismatch_reg   <= '0;
            found_flag_reg <= 1'b0;
        end
        else
        begin
            inc_vld_reg   <= inc_vld_next;
            dec_vld_reg   <= dec_vld_next;
            inc_lw_en_reg <= inc_lw_en_next;
            dec_lw_en_reg <= dec_lw_en_next;
            if (s3_fire)
            begin
                mismatch_reg   <= mismatch_next;
                found_flag_reg <= found_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (inc_we)
        begin
            inc_lw_addr_reg <= s3_letter_reg;
            inc_lw_val_reg  <= inc_wval;
        end
        if (dec_we)
        begin
            dec_lw_addr_reg <= dec_waddr;
            dec_lw_val_reg  <= dec_wval;
        end
        if (s3_fire)
        begin
            window_match_reg <= match_new;
            found_reg        <= found_flag_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign window_match = window_match_reg;
    assign found        = found_reg;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the sliding-window anagram matcher, with its own histogram predictor.
`timescale 1ns / 1ps

module testbench;
    import swam_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int ALPHABET     = 26;
    localparam int RANDOM_ITEMS = 550;
    localparam int LIMIT_CYCLES = 200000;

    // One request as queued for the driver; hold_off makes the driver wait
    // for every outstanding result before presenting it.
    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] letter;
        logic       hold_off;
    } request_t;

    typedef struct packed {
        logic window_match;
        logic found;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic [1:0] cmd = CMD_CLEAR;
    logic [4:0] letter = 5'd0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       window_match;
    logic       found;

    request_t pending_requests[$];
    verdict_t verdicts_due[$];

    int total_requests;
    int requests_taken = 0;
    int results_seen = 0;
    int matches_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Predictor state: pattern and window histograms, ring of recent text
    // letters, and the count of letters whose two histograms disagree.
    logic [6:0] pattern_hist [ALPHABET];
    logic [6:0] window_hist  [ALPHABET];
    logic [4:0] recent_letters [MAX_LEN];
    logic [5:0] ring_wr;
    logic [6:0] pat_len;
    logic [6:0] win_fill;
    logic [4:0] differing;
    logic       seen_match;

    sliding_window_anagram_match DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .letter       (letter),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .window_match (window_match),
        .found        (found)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_histograms();
        for (int i = 0; i < ALPHABET; i++)
        begin
            pattern_hist[i] = '0;
            window_hist[i]  = '0;
        end
        for (int i = 0; i < MAX_LEN; i++)
            recent_letters[i] = '0;
        ring_wr    = '0;
        pat_len    = '0;
        win_fill   = '0;
        differing  = '0;
        seen_match = 1'b0;
    endfunction

    // Keep the disagreement count in step after one letter's counts moved.
    function automatic void retally(logic [4:0] l, logic was_diff);
        logic now_diff;
        now_diff = window_hist[l] != pattern_hist[l];
        if (was_diff && !now_diff)
            differing = differing - 1'b1;
        else if (!was_diff && now_diff)
            differing = differing + 1'b1;
    endfunction

    // Expected result of one request, advancing the predictor state.
    function automatic verdict_t anagram_step(logic [1:0] c, logic [4:0] l);
        verdict_t   v;
        logic [5:0] drop_slot;
        logic [4:0] leaving;
        logic       was_full;
        logic       was_diff;
        v.window_match = 1'b0;
        if (c == CMD_CLEAR)
            clear_histograms();
        else if ((c == CMD_PATTERN || c == CMD_TEXT) && l < ALPHABET)
        begin
            if (c == CMD_PATTERN)
            begin
                // pattern letters past the maximum length are dropped
                if (pat_len < MAX_LEN)
                begin
                    was_diff = window_hist[l] != pattern_hist[l];
                    pattern_hist[l] = pattern_hist[l] + 1'b1;
                    pat_len = pat_len + 1'b1;
                    retally(l, was_diff);
                end
            end
            else
            begin
                // with an empty pattern nothing moves and every letter matches
                if (pat_len != 0)
                begin
                    drop_slot = ring_wr - pat_len[5:0];
                    leaving   = recent_letters[drop_slot];
                    was_full  = win_fill >= pat_len;
                    was_diff  = window_hist[l] != pattern_hist[l];
                    window_hist[l] = window_hist[l] + 1'b1;
                    retally(l, was_diff);
                    if (was_full)
                    begin
                        if (leaving < ALPHABET)
                        begin
                            was_diff = window_hist[leaving] != pattern_hist[leaving];
                            if (window_hist[leaving] != 0)
                                window_hist[leaving] = window_hist[leaving] - 1'b1;
                            retally(leaving, was_diff);
                        end
                    end
                    else
                        win_fill = win_fill + 1'b1;
                    recent_letters[ring_wr] = l;
                    ring_wr = ring_wr + 1'b1;
                end
                if (differing == 0)
                begin
                    v.window_match = 1'b1;
                    seen_match = 1'b1;
                end
            end
        end
        v.found = seen_match;
        return v;
    endfunction

    // Idling mix, stepped every 64 requests: none, sender, receiver, both.
    function automatic int idle_pct(bit receiver);
        case ((requests_taken / 64) % 4)
            1: return receiver ? 0 : 65;
            2: return receiver ? 65 : 0;
            3: return 28;
            default: return 0;
        endcase
    endfunction

    task automatic queue_request(input logic [1:0] c, input logic [4:0] l, input bit hold);
        request_t r;
        r.cmd      = c;
        r.letter   = l;
        r.hold_off = hold;
        pending_requests.push_back(r);
    endtask

    // Driver: a presented request holds until taken; only then may the
    // line go idle or carry the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                verdicts_due.push_back(anagram_step(cmd, letter));
                requests_taken++;
            end
            if (!(cmd_valid && cmd_stall))
            begin
                if (pending_requests.size() > 0
                    && !(pending_requests[0].hold_off && verdicts_due.size() != 0)
                    && $urandom_range(99, 0) >= idle_pct(1'b0))
                begin
                    cmd       <= pending_requests[0].cmd;
                    letter    <= pending_requests[0].letter;
                    cmd_valid <= 1'b1;
                    pending_requests.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Monitor: every result taken is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (window_match === 1'b1)
                    matches_seen++;
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request outstanding: match %b found %b",
                                 $time, window_match, found);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (window_match !== want.window_match || found !== want.found)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d: match %b (want %b), found %b (want %b)",
                                     $time, results_seen, window_match, want.window_match,
                                     found, want.found);
                    end
                end
            end
            res_stall <= $urandom_range(99, 0) < idle_pct(1'b1);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int       plen;
        int       set_base;
        int       set_size;
        int       text_len;
        int       pick;
        int       seq_idx;
        logic [4:0] pat_pick;

        clear_histograms();

        // Directed: empty pattern, unused command, out-of-range letters,
        // alphabet ends, pattern letter arriving after text, clear.
        queue_request(CMD_TEXT, 5'd0, 1'b0);        // empty pattern matches
        queue_request(CMD_SPARE, 5'd31, 1'b0);      // unused command
        queue_request(CMD_CLEAR, 5'd31, 1'b0);
        queue_request(CMD_PATTERN, 5'd0, 1'b0);
        queue_request(CMD_PATTERN, 5'd25, 1'b0);
        queue_request(CMD_PATTERN, 5'd0, 1'b0);
        queue_request(CMD_PATTERN, 5'd26, 1'b0);    // out of range, ignored
        queue_request(CMD_TEXT, 5'd31, 1'b0);       // out of range, ignored
        queue_request(CMD_TEXT, 5'd25, 1'b0);
        queue_request(CMD_TEXT, 5'd0, 1'b0);
        queue_request(CMD_TEXT, 5'd0, 1'b0);        // window "zaa" matches
        queue_request(CMD_TEXT, 5'd1, 1'b0);
        queue_request(CMD_TEXT, 5'd25, 1'b0);
        queue_request(CMD_PATTERN, 5'd1, 1'b0);     // pattern grows mid-text
        queue_request(CMD_TEXT, 5'd0, 1'b0);
        queue_request(CMD_TEXT, 5'd25, 1'b0);
        queue_request(CMD_TEXT, 5'd0, 1'b0);
        queue_request(CMD_SPARE, 5'd0, 1'b0);
        queue_request(CMD_CLEAR, 5'd0, 1'b1);       // wait for results first
        queue_request(CMD_TEXT, 5'd25, 1'b0);

        // Random: mostly clear / pattern / text sequences over a narrow
        // letter set so windows match often, with stray noise mixed in.
        seq_idx = 0;
        while (pending_requests.size() < RANDOM_ITEMS + 20)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 85)
            begin
                queue_request(CMD_CLEAR, 5'($urandom_range(31, 0)), seq_idx % 10 == 0);
                if (seq_idx == 0)
                    plen = 66;                      // overruns the pattern store
                else if ($urandom_range(99, 0) < 6)
                    plen = $urandom_range(70, 58);
                else
                    plen = $urandom_range(6, 1);
                set_size = $urandom_range(4, 1);
                set_base = $urandom_range(ALPHABET - set_size, 0);
                for (int i = 0; i < plen; i++)
                begin
                    pat_pick = 5'(set_base + $urandom_range(set_size - 1, 0));
                    queue_request(CMD_PATTERN, pat_pick, 1'b0);
                end
                text_len = plen + $urandom_range(12, 0);
                for (int i = 0; i < text_len; i++)
                begin
                    pick = $urandom_range(99, 0);
                    pat_pick = 5'(set_base + $urandom_range(set_size - 1, 0));
                    if (pick < 4)
                        queue_request(CMD_PATTERN, pat_pick, 1'b0);
                    else if (pick < 10)
                        queue_request(2'($urandom_range(3, 0)), 5'($urandom_range(31, 0)),
                                      1'b0);
                    else
                        queue_request(CMD_TEXT, pat_pick, 1'b0);
                end
                seq_idx++;
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    queue_request(2'($urandom_range(3, 0)), 5'($urandom_range(31, 0)), 1'b0);
            end
        end
        total_requests = pending_requests.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (!(requests_taken == total_requests && verdicts_due.size() == 0))
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d requests in %0d pattern/text sequences; %0d results, %0d window matches.",
                 requests_taken, seq_idx, results_seen, matches_seen);
        $display("Mismatched or stray results: %0d.", mismatches);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
